// ----- sv/dadd_pkg.sv -----
package dadd_pkg;

  localparam int MAX_YEAR = 9999;
  localparam logic [21:0] MAX_DAY =
    22'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_BEFORE = 2'd2;
  localparam logic [1:0] ST_PAST = 2'd3;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [1:0] status;
    logic [21:0] num;
  } dadd_item_t;

  function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = lp ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days in months before month m of a common year
  function automatic logic [8:0] cum_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'd0;
      4'd2: r = 9'd31;
      4'd3: r = 9'd59;
      4'd4: r = 9'd90;
      4'd5: r = 9'd120;
      4'd6: r = 9'd151;
      4'd7: r = 9'd181;
      4'd8: r = 9'd212;
      4'd9: r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/gregorian_date_add_days_top.sv -----
// Adds a signed day offset to a proleptic Gregorian date. Nine register
// stages, one item per cycle while the output is not stalled; a stalled
// output holds the whole pipeline. Status 0 is ok,
// 1 an invalid start date, 2 a result before 0001-01-01, 3 a result past
// 9999-12-31; on error the start date is returned and day_number is 0.
module gregorian_date_add_days_top import dadd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [13:0] start_year,
  input  logic [3:0] start_month,
  input  logic [4:0] start_day,
  input  logic signed [22:0] delta_days,
  output logic out_valid,
  input  logic out_ready,
  output logic [13:0] end_year,
  output logic [3:0] end_month,
  output logic [4:0] end_day,
  output logic [21:0] day_number,
  output logic [1:0] status
);

  logic adv;
  logic b_valid, g_valid;
  dadd_item_t b_item, g_item;
  logic signed [24:0] b_sum;
  logic [4:0] g_q400, g_q4;
  logic [1:0] g_c;
  logic [10:0] g_r;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  dadd_front u_front (
    .clk, .rst, .adv, .in_valid, .start_year, .start_month, .start_day, .delta_days,
    .b_valid, .b_item, .b_sum
  );

  dadd_split u_split (
    .clk, .rst, .adv, .b_valid, .b_item, .b_sum,
    .g_valid, .g_item, .g_q400, .g_c, .g_q4, .g_r
  );

  dadd_back u_back (
    .clk, .rst, .adv, .g_valid, .g_item, .g_q400, .g_c, .g_q4, .g_r,
    .out_valid, .end_year, .end_month, .end_day, .day_number, .status
  );

endmodule

// ----- sv/dadd_front.sv -----
module dadd_front import dadd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [13:0] start_year,
  input  logic [3:0] start_month,
  input  logic [4:0] start_day,
  input  logic signed [22:0] delta_days,
  output logic b_valid,
  output dadd_item_t b_item,
  output logic signed [24:0] b_sum
);

  logic a_valid;
  logic [13:0] a_year;
  logic [3:0] a_month;
  logic [4:0] a_day;
  logic signed [22:0] a_delta;
  logic [23:0] a_p365;
  logic [7:0] a_qp;
  logic [7:0] a_qy;

  logic [13:0] p;
  logic [26:0] prod_p;
  logic [26:0] prod_y;
  logic [13:0] a_p;
  logic lp;
  logic [4:0] mlen;
  logic bad;
  logic signed [24:0] sum;
  logic [1:0] st;

  assign p = start_year - 14'd1;
  assign prod_p = 27'(p) * 27'd5243;
  assign prod_y = 27'(start_year) * 27'd5243;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_year <= start_year;
      a_month <= start_month;
      a_day <= start_day;
      a_delta <= delta_days;
      a_p365 <= 24'(p) * 24'd365;
      a_qp <= prod_p[26:19];
      a_qy <= prod_y[26:19];
    end
  end

  assign a_p = a_year - 14'd1;
  assign lp = (a_year[1:0] == 2'd0) &&
              ((a_year != 14'(16'(a_qy) * 16'd100)) || (a_qy[1:0] == 2'd0));
  assign mlen = month_len(lp, a_month);
  assign bad = (a_year == 14'd0) || (a_year > 14'(MAX_YEAR)) || (a_month == 4'd0) ||
               (a_month > 4'd12) || (a_day == 5'd0) || (a_day > mlen);
  assign sum = 25'(a_p365) + 25'(a_p >> 2) - 25'(a_qp) + 25'(a_qp >> 2) +
               25'(cum_before(a_month)) + 25'(lp && (a_month > 4'd2)) + 25'(a_day) +
               25'(a_delta);

  always_comb begin
    if (bad) begin
      st = ST_BAD_DATE;
    end else if (sum < 25'sd1) begin
      st = ST_BEFORE;
    end else if (sum > $signed(25'(MAX_DAY))) begin
      st = ST_PAST;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_item.year <= a_year;
      b_item.month <= a_month;
      b_item.day <= a_day;
      b_item.status <= st;
      b_item.num <= sum[21:0];
      b_sum <= sum;
    end
  end

endmodule

// ----- sv/dadd_split.sv -----
module dadd_split import dadd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic b_valid,
  input  dadd_item_t b_item,
  input  logic signed [24:0] b_sum,
  output logic g_valid,
  output dadd_item_t g_item,
  output logic [4:0] g_q400,
  output logic [1:0] g_c,
  output logic [4:0] g_q4,
  output logic [10:0] g_r
);

  logic c_valid, d_valid, e_valid, f_valid;
  dadd_item_t c_item, d_item, e_item, f_item;
  logic [21:0] c_n;
  logic [4:0] c_q;
  logic [4:0] d_q400, e_q400, f_q400;
  logic [17:0] d_r;
  logic [1:0] e_c, f_c;
  logic [15:0] e_r, f_r;
  logic [4:0] f_q;

  logic [21:0] n;
  logic [36:0] prod_n;
  logic [22:0] t400;
  logic [1:0] cs;
  logic [31:0] prod_r;
  logic [15:0] t4;

  assign n = b_sum[21:0] - 22'd1;
  assign prod_n = 37'(n) * 37'd29398;
  assign t400 = 23'(c_n) - 23'(c_q) * 23'd146097;
  assign prod_r = 32'(e_r) * 32'd45933;
  assign t4 = f_r - 16'(f_q) * 16'd1461;

  always_comb begin
    if (d_r >= 18'd109572) begin
      cs = 2'd3;
    end else if (d_r >= 18'd73048) begin
      cs = 2'd2;
    end else if (d_r >= 18'd36524) begin
      cs = 2'd1;
    end else begin
      cs = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
    if (adv) begin
      c_item <= b_item;
      c_n <= n;
      c_q <= prod_n[36:32];
      d_item <= c_item;
      if (t400 >= 23'd146097) begin
        d_q400 <= c_q + 5'd1;
        d_r <= 18'(t400 - 23'd146097);
      end else begin
        d_q400 <= c_q;
        d_r <= t400[17:0];
      end
      e_item <= d_item;
      e_q400 <= d_q400;
      e_c <= cs;
      e_r <= 16'(d_r - 18'(cs) * 18'd36524);
      f_item <= e_item;
      f_q400 <= e_q400;
      f_c <= e_c;
      f_r <= e_r;
      f_q <= prod_r[30:26];
      g_item <= f_item;
      g_q400 <= f_q400;
      g_c <= f_c;
      if (t4 >= 16'd1461) begin
        g_q4 <= f_q + 5'd1;
        g_r <= 11'(t4 - 16'd1461);
      end else begin
        g_q4 <= f_q;
        g_r <= t4[10:0];
      end
    end
  end

endmodule

// ----- sv/dadd_back.sv -----
module dadd_back import dadd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic g_valid,
  input  dadd_item_t g_item,
  input  logic [4:0] g_q400,
  input  logic [1:0] g_c,
  input  logic [4:0] g_q4,
  input  logic [10:0] g_r,
  output logic out_valid,
  output logic [13:0] end_year,
  output logic [3:0] end_month,
  output logic [4:0] end_day,
  output logic [21:0] day_number,
  output logic [1:0] status
);

  logic h_valid;
  dadd_item_t h_item;
  logic [13:0] h_yr;
  logic [8:0] h_r;
  logic h_lp;

  logic [1:0] y1;
  logic [3:0] mo;
  logic [8:0] dd;

  always_comb begin
    if (g_r >= 11'd1095) begin
      y1 = 2'd3;
    end else if (g_r >= 11'd730) begin
      y1 = 2'd2;
    end else if (g_r >= 11'd365) begin
      y1 = 2'd1;
    end else begin
      y1 = 2'd0;
    end
  end

  always_comb begin
    mo = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (h_r > cum_before(4'(k + 1)) + 9'(h_lp && (k >= 2))) begin
        mo = 4'(k + 1);
      end
    end
    dd = h_r - cum_before(mo) - 9'(h_lp && (mo > 4'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= g_valid;
      out_valid <= h_valid;
    end
    if (adv) begin
      h_item <= g_item;
      h_yr <= 14'(g_q400) * 14'd400 + 14'(g_c) * 14'd100 + 14'(g_q4) * 14'd4 +
              14'(y1) + 14'd1;
      h_r <= 9'(g_r - 11'(y1) * 11'd365 + 11'd1);
      h_lp <= (y1 == 2'd3) && ((g_q4 != 5'd24) || (g_c == 2'd3));
      status <= h_item.status;
      if (h_item.status == ST_OK) begin
        end_year <= h_yr;
        end_month <= mo;
        end_day <= dd[4:0];
        day_number <= h_item.num;
      end else begin
        end_year <= h_item.year;
        end_month <= h_item.month;
        end_day <= h_item.day;
        day_number <= 22'd0;
      end
    end
  end

endmodule

// ----- sv/dadd_checker.sv -----
module dadd_checker import dadd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [4:0] end_day,
  input logic [3:0] end_month,
  input logic [21:0] day_number,
  input logic [1:0] status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> end_day != 5'd0 && end_month != 4'd0 &&
    end_month <= 4'd12 && day_number != 22'd0) else $error("bad result date");

  a_err_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> day_number == 22'd0) else $error("error with day");

endmodule

bind gregorian_date_add_days_top dadd_checker u_dadd_checker (
  .clk, .rst, .out_valid, .out_ready, .end_day, .end_month, .day_number, .status
);
